### hw/rtl/mirb_pkg.sv
// ----------------------------------------------------------------------------
// mirb_pkg
// Shared types and constants of the micro I/O register block: the word map,
// the configuration map and the request and result records.
// ----------------------------------------------------------------------------
package mirb_pkg;

	localparam logic [15:0] ADDR_KEY_FLAG   = 16'hFFB0;
	localparam logic [15:0] ADDR_KEY_CODE   = 16'hFFB2;
	localparam logic [15:0] ADDR_SCROLL     = 16'hFFB4;
	localparam logic [15:0] ADDR_SAVED_PC   = 16'hFFBC;
	localparam logic [15:0] ADDR_SAVED_PSW  = 16'hFFBE;
	localparam logic [15:0] ADDR_TMR_RELOAD = 16'hFFC6;
	localparam logic [15:0] ADDR_TMR_VALUE  = 16'hFFC8;
	localparam logic [15:0] ADDR_TMR_FLAGS  = 16'hFFCA;
	localparam logic [15:0] ADDR_EXT_PORT   = 16'hFFCC;
	localparam logic [15:0] ADDR_SYS_PORT   = 16'hFFCE;

	localparam logic [15:0] SYS_BASE_LARGE  = 16'hC000;
	localparam logic [15:0] SYS_BASE_SMALL  = 16'h8000;
	localparam logic [15:0] RD_UNMAPPED     = 16'hFFFF;
	localparam logic [15:0] TMR_FLAGS_FILL  = 16'hFF00;

	localparam logic       OP_READ  = 1'b0;
	localparam logic       OP_WRITE = 1'b1;

	localparam int         PADDR_W       = 3;
	localparam logic [2:0] CFG_ADDR_MODEL = 3'd0;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 48;

	typedef struct packed {
		logic        operation;
		logic [15:0] address;
		logic [15:0] write_data;
		logic [1:0]  byte_lanes;
		logic [6:0]  key_code;
		logic        key_ready;
		logic        key_held;
		logic        tape_level_high;
		logic        tape_recording;
		logic [15:0] saved_pc;
		logic [15:0] saved_psw;
	} request_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        tape_running;
		logic        beep_level;
		logic        screen_page;
		logic [3:0]  palette_number;
		logic [7:0]  scroll_line;
		logic        screen_cut;
		logic        frame_irq_enable;
		logic [2:0]  window0_page;
		logic        window1_rom;
		logic [2:0]  window1_page;
		logic [2:0]  timer_period_shift;
	} result_t;

	function automatic logic [15:0] lane_merge(input logic [15:0] old_word,
			input logic [15:0] new_word, input logic [1:0] lanes);
		logic [15:0] merged;
		merged = old_word;
		if (lanes[0]) merged[7:0] = new_word[7:0];
		if (lanes[1]) merged[15:8] = new_word[15:8];
		return merged;
	endfunction

endpackage

### hw/rtl/mirb_regs.sv
// ----------------------------------------------------------------------------
// mirb_regs
// Register file and decode: serves one bus request from the input stage,
// updates the system registers and forms the result record.
// ----------------------------------------------------------------------------
module mirb_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               model_select,
	input  logic               advance,
	input  mirb_pkg::request_t req,
	output mirb_pkg::result_t  res
);

	logic        key_irq_off_q, key_irq_off_d;
	logic        vid_mask_q, vid_mask_d;
	logic [3:0]  palette_q, palette_d;
	logic        page_q, page_d;
	logic [7:0]  scroll_q, scroll_d;
	logic        cut_q, cut_d;
	logic [15:0] reload_q, reload_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  flags_q, flags_d;
	logic [2:0]  shift_q, shift_d;
	logic        port_wr_q, port_wr_d;
	logic        motor_q, motor_d;
	logic        beep_q, beep_d;
	logic [2:0]  win0_q, win0_d;
	logic        win1_rom_q, win1_rom_d;
	logic [2:0]  win1_page_q, win1_page_d;

	logic [15:0] adr;
	logic [15:0] wd;
	logic [15:0] rd;
	logic        ctrl_wr;

	assign adr = {req.address[15:1], 1'b0};
	assign wd  = req.write_data;

	always_comb begin
		key_irq_off_d = key_irq_off_q;
		vid_mask_d    = vid_mask_q;
		palette_d     = palette_q;
		page_d        = page_q;
		scroll_d      = scroll_q;
		cut_d         = cut_q;
		reload_d      = reload_q;
		count_d       = count_q;
		flags_d       = flags_q;
		shift_d       = shift_q;
		port_wr_d     = port_wr_q;
		motor_d       = motor_q;
		beep_d        = beep_q;
		win0_d        = win0_q;
		win1_rom_d    = win1_rom_q;
		win1_page_d   = win1_page_q;
		ctrl_wr       = 1'b0;
		rd            = 16'h0000;
		if (req.operation == mirb_pkg::OP_READ) begin
			case (adr)
				mirb_pkg::ADDR_KEY_FLAG: rd = {8'h00, req.key_ready, key_irq_off_q, 6'h00};
				mirb_pkg::ADDR_KEY_CODE: rd = {9'h000, req.key_code};
				mirb_pkg::ADDR_SCROLL: rd = {6'h00, !cut_q, 1'b0, scroll_q};
				mirb_pkg::ADDR_SAVED_PC: rd = req.saved_pc;
				mirb_pkg::ADDR_SAVED_PSW: rd = req.saved_psw;
				mirb_pkg::ADDR_TMR_RELOAD: rd = reload_q;
				mirb_pkg::ADDR_TMR_VALUE: rd = count_q;
				mirb_pkg::ADDR_TMR_FLAGS: rd = mirb_pkg::TMR_FLAGS_FILL | {8'h00, flags_q};
				mirb_pkg::ADDR_EXT_PORT: rd = 16'h0000;
				mirb_pkg::ADDR_SYS_PORT: begin
					rd = model_select ? mirb_pkg::SYS_BASE_LARGE : mirb_pkg::SYS_BASE_SMALL;
					rd[2] = port_wr_q;
					rd[5] = motor_q && !req.tape_recording && req.tape_level_high;
					rd[6] = !req.key_held;
					port_wr_d = 1'b0;
				end
				default: rd = mirb_pkg::RD_UNMAPPED;
			endcase
		end else begin
			case (adr)
				mirb_pkg::ADDR_KEY_FLAG: key_irq_off_d = wd[6];
				mirb_pkg::ADDR_KEY_CODE: begin
					if (model_select) begin
						vid_mask_d = wd[14];
						palette_d  = wd[11:8];
						page_d     = wd[15];
					end
				end
				mirb_pkg::ADDR_SCROLL: begin
					if (req.byte_lanes[0]) scroll_d = wd[7:0];
					if (req.byte_lanes[1]) cut_d = !wd[9];
				end
				mirb_pkg::ADDR_TMR_RELOAD: reload_d = mirb_pkg::lane_merge(reload_q, wd,
						req.byte_lanes);
				mirb_pkg::ADDR_TMR_VALUE: count_d = mirb_pkg::lane_merge(count_q, wd,
						req.byte_lanes);
				mirb_pkg::ADDR_TMR_FLAGS: begin
					if (req.byte_lanes[0]) begin
						flags_d = wd[7:0];
						shift_d = {wd[5], wd[6], 1'b0};
						if (wd[4] || wd[1]) count_d = reload_q;
					end
				end
				mirb_pkg::ADDR_SYS_PORT: begin
					if (model_select) begin
						if (wd[11]) begin
							if (wd[4]) begin
								win1_rom_d = 1'b1; win1_page_d = 3'd3;
							end else if (wd[3]) begin
								win1_rom_d = 1'b1; win1_page_d = 3'd2;
							end else if (wd[1]) begin
								win1_rom_d = 1'b1; win1_page_d = 3'd1;
							end else if (wd[0]) begin
								win1_rom_d = 1'b1; win1_page_d = 3'd0;
							end else begin
								win1_rom_d = 1'b0; win1_page_d = wd[10:8];
							end
							win0_d = wd[14:12];
						end else begin
							ctrl_wr = (req.byte_lanes == 2'b11);
						end
					end else begin
						ctrl_wr = req.byte_lanes[0];
					end
				end
				default: ;
			endcase
			if (ctrl_wr) begin
				if (!wd[7] && !motor_q) begin
					motor_d = 1'b1;
				end else if (wd[7] && motor_q && !req.tape_recording) begin
					motor_d = 1'b0;
				end
				beep_d    = wd[6];
				port_wr_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_irq_off_q <= 1'b0;
			vid_mask_q    <= 1'b1;
			palette_q     <= '0;
			page_q        <= 1'b0;
			scroll_q      <= '0;
			cut_q         <= 1'b0;
			reload_q      <= '0;
			count_q       <= '0;
			flags_q       <= '0;
			shift_q       <= '0;
			port_wr_q     <= 1'b0;
			motor_q       <= 1'b0;
			beep_q        <= 1'b0;
			win0_q        <= '0;
			win1_rom_q    <= 1'b1;
			win1_page_q   <= '0;
		end else if (advance) begin
			key_irq_off_q <= key_irq_off_d;
			vid_mask_q    <= vid_mask_d;
			palette_q     <= palette_d;
			page_q        <= page_d;
			scroll_q      <= scroll_d;
			cut_q         <= cut_d;
			reload_q      <= reload_d;
			count_q       <= count_d;
			flags_q       <= flags_d;
			shift_q       <= shift_d;
			port_wr_q     <= port_wr_d;
			motor_q       <= motor_d;
			beep_q        <= beep_d;
			win0_q        <= win0_d;
			win1_rom_q    <= win1_rom_d;
			win1_page_q   <= win1_page_d;
		end
	end

	always_comb begin
		res.read_data          = rd;
		res.tape_running       = motor_d;
		res.beep_level         = beep_d;
		res.screen_page        = page_d;
		res.palette_number     = palette_d;
		res.scroll_line        = scroll_d;
		res.screen_cut         = cut_d;
		res.frame_irq_enable   = !vid_mask_d;
		res.window0_page       = win0_d;
		res.window1_rom        = win1_rom_d;
		res.window1_page       = win1_page_d;
		res.timer_period_shift = shift_d;
	end

	a_shift_even: assert property (@(posedge clk) disable iff (!arst_n) !shift_q[0])
		else $error("timer prescale shift is odd");

	a_rom_page_range: assert property (@(posedge clk) disable iff (!arst_n)
			win1_rom_q |-> !win1_page_q[2])
		else $error("ROM window page out of range");

	a_port_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
			(advance && req.operation == mirb_pkg::OP_READ && adr == mirb_pkg::ADDR_SYS_PORT)
			|=> !port_wr_q)
		else $error("system port read did not clear written flag");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
			(advance && req.operation == mirb_pkg::OP_WRITE) |-> (res.read_data == 16'h0000))
		else $error("write request returned nonzero read data");

endmodule

### hw/rtl/micro_io_register_block.sv
// ----------------------------------------------------------------------------
// micro_io_register_block
// System register set of a 16-bit home computer behind a stream interface.
// ----------------------------------------------------------------------------
// Each bus request is registered, decoded against the system register map
// and its result (read word plus the current control outputs) is held in an
// output register. Throughput is one request per clock unless m_tready stalls
// the output; a request passes the input register, then the result register.
// Requests take effect on the register state in acceptance order. The APB
// port holds model_select (offset 0, reset 1).
// ----------------------------------------------------------------------------
module micro_io_register_block (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mirb_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [15:0] address, [31:16] write_data, [33:32] byte_lanes, [40:34] key_code,
	// [41] key_ready, [42] key_held, [43] tape_level_high, [44] tape_recording,
	// [60:45] saved_pc, [76:61] saved_psw, [79:77] zero
	input  logic [mirb_pkg::S_TDATA_W-1:0]    s_tdata,
	// [0] operation
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [15:0] read_data, [16] tape_running, [17] beep_level, [18] screen_page,
	// [22:19] palette_number, [30:23] scroll_line, [31] screen_cut,
	// [32] frame_irq_enable, [35:33] window0_page, [36] window1_rom,
	// [39:37] window1_page, [42:40] timer_period_shift, [47:43] zero
	output logic [mirb_pkg::M_TDATA_W-1:0]    m_tdata
);

	logic               model_q;
	logic               valid_s1;
	mirb_pkg::request_t req_s1;
	logic               out_valid_s2;
	mirb_pkg::result_t  res_s2;
	mirb_pkg::result_t  res;
	logic               advance;

	assign pready = 1'b1;
	assign prdata = (paddr == mirb_pkg::CFG_ADDR_MODEL) ? {31'h0, model_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= 1'b1;
		end else if (psel && penable && pwrite && pready &&
				paddr == mirb_pkg::CFG_ADDR_MODEL) begin
			model_q <= pwdata[0];
		end
	end

	assign advance  = valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.operation       <= s_tuser;
			req_s1.address         <= s_tdata[15:0];
			req_s1.write_data      <= s_tdata[31:16];
			req_s1.byte_lanes      <= s_tdata[33:32];
			req_s1.key_code        <= s_tdata[40:34];
			req_s1.key_ready       <= s_tdata[41];
			req_s1.key_held        <= s_tdata[42];
			req_s1.tape_level_high <= s_tdata[43];
			req_s1.tape_recording  <= s_tdata[44];
			req_s1.saved_pc        <= s_tdata[60:45];
			req_s1.saved_psw       <= s_tdata[76:61];
		end
	end

	mirb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.model_select (model_q),
		.advance      (advance),
		.req          (req_s1),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {5'h00, res_s2.timer_period_shift, res_s2.window1_page,
			res_s2.window1_rom, res_s2.window0_page, res_s2.frame_irq_enable,
			res_s2.screen_cut, res_s2.scroll_line, res_s2.palette_number,
			res_s2.screen_page, res_s2.beep_level, res_s2.tape_running, res_s2.read_data};

endmodule
